// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define SCDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define SCDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo chorus package
// Sizes, configuration and control types, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package scdm_pkg;

    // Store and table sizes
    localparam int HISTORY_DEPTH = 131072;
    localparam int SINE_ENTRIES  = 1024;

    localparam int ADDR_W     = $clog2(HISTORY_DEPTH);
    localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int SINE_IDX_W = $clog2(SINE_ENTRIES);
    localparam int SINE_QW    = SINE_IDX_W - 2;
    localparam int SINE_Q     = SINE_ENTRIES / 4;
    // shift from in-quadrant index to the Q0.15 angle
    localparam int SINE_XSHIFT = 32 - SINE_IDX_W - 15;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 17;
    localparam int PHASE_W  = 32;
    localparam int GAIN_W   = 17;
    localparam int MAG_W    = 15;

    // Datapath widths
    localparam int MUL_A_W = 19;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 36;
    localparam int DCMP_W  = (ADDR_W >= 19) ? ADDR_W + 1 : 19;
    localparam int MIX_SHIFT = 17;

    localparam logic [GAIN_W-1:0]   GAIN_UNITY = GAIN_W'(65536);
    localparam logic [MAG_W-1:0]    MAG_MAX    = {MAG_W{1'b1}};
    localparam logic [ACC_W-1:0]    ROUND_HALF = ACC_W'(65536);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Sine polynomial coefficients
    localparam longint POLY_A = 51472;
    localparam longint POLY_B = 21089;
    localparam longint POLY_C = 2385;

    // APB register map
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam logic [2:0] REG_BASE_DELAY = 3'd0;
    localparam logic [2:0] REG_MOD_DEPTH  = 3'd1;
    localparam logic [2:0] REG_LFO_STEP   = 3'd2;
    localparam logic [2:0] REG_WET_GAIN   = 3'd3;
    localparam logic [2:0] REG_DRY_GAIN   = 3'd4;

    typedef struct packed {
        logic [DELAY_W-1:0] base_delay;
        logic [DELAY_W-1:0] mod_depth;
        logic [PHASE_W-1:0] lfo_step;
        logic [GAIN_W-1:0]  wet_gain;
        logic [GAIN_W-1:0]  dry_gain;
    } t_cfg;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWING,
        ST_DELAY,
        ST_READ,
        ST_MIX_LW,
        ST_MIX_LD,
        ST_MIX_RW,
        ST_MIX_RD,
        ST_DONE
    } t_state;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MUL_SWING,
        MUL_LW,
        MUL_LD,
        MUL_RW,
        MUL_RD
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    write;
        logic    delay;
        logic    read;
        logic    mul_en;
        t_mul_op mul_op;
        logic    acc_l_load;
        logic    acc_l_add;
        logic    acc_r_load;
        logic    finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // First quadrant of the sine magnitude, Q0.15
    typedef logic [MAG_W-1:0] t_sine_quarter [SINE_Q];

    function automatic t_sine_quarter build_sine_quarter();
        t_sine_quarter tbl;
        longint x;
        longint x2;
        longint x3;
        longint x5;
        longint mag;
        for (int k = 0; k < SINE_Q; k++) begin
            x   = longint'(k) << SINE_XSHIFT;
            x2  = (x * x) >>> 15;
            x3  = (x2 * x) >>> 15;
            x5  = (x3 * x2) >>> 15;
            mag = (POLY_A * x - POLY_B * x3 + POLY_C * x5) >>> 15;
            if (mag > 32767) begin
                mag = 32767;
            end
            if (mag < 0) begin
                mag = 0;
            end
            tbl[k] = MAG_W'(mag);
        end
        return tbl;
    endfunction

    localparam t_sine_quarter SINE_QUARTER = build_sine_quarter();

endpackage

`default_nettype wire

// ===== rtl/scdm_in_if.sv =====
// ----------------------------------------------------------------------------
// Stereo input channel
// Valid/ready channel carrying one stereo sample pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scdm_in_if import scdm_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);

endinterface

`default_nettype wire

// ===== rtl/scdm_out_if.sv =====
// ----------------------------------------------------------------------------
// Stereo output channel
// Valid/ready channel carrying one processed stereo pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scdm_out_if import scdm_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);

endinterface

`default_nettype wire

// ===== rtl/stereo_chorus_delay_mix.sv =====
// ----------------------------------------------------------------------------
// Stereo chorus delay mix
// Modulated delay line per channel, mixed with the dry input.
// ----------------------------------------------------------------------------
//  Channel    Port      Kind        Beat
//  input      i_sample  valid/ready one stereo pair: left_in, right_in
//  output     o_sample  valid/ready one stereo pair: left_out, right_out
//  config     psel...   APB         one 32-bit register write or read
//
//  An item runs from its accepting edge through the swing, delay, read
//  and mix steps to the output register, as the single shared
//  multiplier (swing and four mix products) and the registered store
//  read serialise them. The next item is accepted only back in idle,
//  so one item is in work at a time. Reset is synchronous; the history
//  store is not swept: a fill count makes unwritten entries read zero.
//  While a result waits in the output register, the next item runs up to
//  its last step and holds there until the output beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_chorus_delay_mix import scdm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    scdm_in_if.sink                    i_sample,
    scdm_out_if.source                 o_sample,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // Configuration registers
    scdm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    scdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Datapath
    scdm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_left_in   (i_sample.left_in),
        .i_right_in  (i_sample.right_in),
        .i_out_ready (o_sample.ready),
        .o_status    (status),
        .o_out_valid (o_sample.valid),
        .o_left_out  (o_sample.left_out),
        .o_right_out (o_sample.right_out)
    );

    assign i_sample.ready = in_ready;

endmodule

`default_nettype wire

// ===== rtl/scdm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/scdm_regs.sv =====
// ----------------------------------------------------------------------------
// Chorus configuration registers
// APB slave holding delay, depth, LFO step and mix gains.
// ----------------------------------------------------------------------------
`default_nettype none

module scdm_regs import scdm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready,
    output      t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_beat;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_beat = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // Update the addressed register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_beat) begin
            case (reg_idx)
                REG_BASE_DELAY: r_cfg.base_delay <= pwdata[DELAY_W-1:0];
                REG_MOD_DEPTH:  r_cfg.mod_depth  <= pwdata[DELAY_W-1:0];
                REG_LFO_STEP:   r_cfg.lfo_step   <= pwdata[PHASE_W-1:0];
                REG_WET_GAIN:   r_cfg.wet_gain   <= pwdata[GAIN_W-1:0];
                REG_DRY_GAIN:   r_cfg.dry_gain   <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_BASE_DELAY: prdata = APB_DATA_W'(r_cfg.base_delay);
            REG_MOD_DEPTH:  prdata = APB_DATA_W'(r_cfg.mod_depth);
            REG_LFO_STEP:   prdata = APB_DATA_W'(r_cfg.lfo_step);
            REG_WET_GAIN:   prdata = APB_DATA_W'(r_cfg.wet_gain);
            REG_DRY_GAIN:   prdata = APB_DATA_W'(r_cfg.dry_gain);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/scdm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Chorus controller
// Sequences one stereo pair through swing, delay, read and mix steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scdm_ctrl import scdm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output      logic    o_in_ready,
    output      t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        case (r_state)
            ST_IDLE:   n_state = i_in_valid ? ST_SWING : ST_IDLE;
            ST_SWING:  n_state = ST_DELAY;
            ST_DELAY:  n_state = ST_READ;
            ST_READ:   n_state = ST_MIX_LW;
            ST_MIX_LW: n_state = ST_MIX_LD;
            ST_MIX_LD: n_state = ST_MIX_RW;
            ST_MIX_RW: n_state = ST_MIX_RD;
            ST_MIX_RD: n_state = ST_DONE;
            ST_DONE:   n_state = i_status.out_free ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Commands; refuse input beats while in reset
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_SWING: begin
                o_cmd.write  = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_SWING;
            end
            ST_DELAY: begin
                o_cmd.delay = 1'b1;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
            end
            ST_MIX_LW: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_LW;
            end
            ST_MIX_LD: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_op     = MUL_LD;
                o_cmd.acc_l_load = 1'b1;
            end
            ST_MIX_RW: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_op    = MUL_RW;
                o_cmd.acc_l_add = 1'b1;
            end
            ST_MIX_RD: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_op     = MUL_RD;
                o_cmd.acc_r_load = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: ;
        endcase
    end

    `SCDM_ASSERT_NEXT(a_load_starts, o_cmd.load, r_state == ST_SWING, "accepted beat did not start work")
    `SCDM_ASSERT_NEXT(a_done_waits, r_state == ST_DONE && !i_status.out_free, r_state == ST_DONE, "result left before output freed")

endmodule

`default_nettype wire

// ===== rtl/scdm_dpath.sv =====
// ----------------------------------------------------------------------------
// Chorus datapath
// Sine LFO, delay store, shared multiplier, mix accumulators, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scdm_dpath import scdm_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cmd                       i_cmd,
    input  wire t_cfg                       i_cfg,
    input  wire logic signed [SAMPLE_W-1:0] i_left_in,
    input  wire logic signed [SAMPLE_W-1:0] i_right_in,
    input  wire logic                       i_out_ready,
    output      t_status                    o_status,
    output      logic                       o_out_valid,
    output      logic signed [SAMPLE_W-1:0] o_left_out,
    output      logic signed [SAMPLE_W-1:0] o_right_out
);

    // Control registers
    logic [ADDR_W-1:0]  r_wp;
    logic [ADDR_W-1:0]  n_wp;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic [PHASE_W-1:0] r_phase;
    logic               r_out_valid;

    // Payload registers
    logic signed [SAMPLE_W-1:0] r_left_in;
    logic signed [SAMPLE_W-1:0] r_right_in;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_neg;
    logic signed [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]          r_delay;
    logic [ADDR_W-1:0]          n_delay;
    logic                       r_hit;
    logic signed [ACC_W-1:0]    r_acc_l;
    logic signed [ACC_W-1:0]    r_acc_r;
    logic signed [SAMPLE_W-1:0] r_left_out;
    logic signed [SAMPLE_W-1:0] r_right_out;

    // Sine lookup
    logic [SINE_IDX_W-1:0] sine_idx;
    logic [SINE_QW-1:0]    sine_j;
    logic [SINE_QW:0]      sine_k;
    logic [MAG_W-1:0]      sine_mag;

    // Delay and read address
    logic [DELAY_W-1:0]       swing;
    logic signed [DCMP_W-1:0] dsum;
    logic [ADDR_W-1:0]        rd_addr;

    // Mix
    logic [2*SAMPLE_W-1:0]      ram_rd_data;
    logic signed [SAMPLE_W-1:0] dl_left;
    logic signed [SAMPLE_W-1:0] dl_right;
    logic signed [SAMPLE_W:0]   sum_left;
    logic signed [SAMPLE_W:0]   sum_right;
    logic [GAIN_W-1:0]          wet_c;
    logic [GAIN_W-1:0]          dry_c;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    total_r;

    // Round half up and saturate a mix total to one sample
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] total);
        logic signed [ACC_W-1:0] q;
        logic [SAMPLE_W-1:0]     res;
        q = (total + $signed(ROUND_HALF)) >>> MIX_SHIFT;
        if (q[ACC_W-1:SAMPLE_W-1] == '0 || q[ACC_W-1:SAMPLE_W-1] == '1) begin
            res = q[SAMPLE_W-1:0];
        end else begin
            res = q[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
        return res;
    endfunction

    // Look up the sine magnitude from the current phase, mirrored per quadrant
    always_comb begin
        sine_idx = r_phase[PHASE_W-1 -: SINE_IDX_W];
        sine_j   = sine_idx[SINE_QW-1:0];
        sine_k   = sine_idx[SINE_QW] ? (SINE_QW+1)'(SINE_Q) - {1'b0, sine_j}
                                     : {1'b0, sine_j};
        sine_mag = sine_k[SINE_QW] ? MAG_MAX : SINE_QUARTER[sine_k[SINE_QW-1:0]];
    end

    // Advance write pointer and fill count on each accepted beat
    always_comb begin
        n_wp   = (r_wp == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_fill = (r_fill == FILL_W'(HISTORY_DEPTH)) ? r_fill : r_fill + 1'b1;
    end

    // Apply the signed swing to the base delay and clamp to the store
    always_comb begin
        swing = r_prod[MAG_W +: DELAY_W];
        if (r_neg) begin
            dsum = $signed(DCMP_W'(i_cfg.base_delay)) - $signed(DCMP_W'(swing));
        end else begin
            dsum = $signed(DCMP_W'(i_cfg.base_delay)) + $signed(DCMP_W'(swing));
        end
        if (dsum[DCMP_W-1]) begin
            n_delay = '0;
        end else if (dsum > $signed(DCMP_W'(HISTORY_DEPTH - 1))) begin
            n_delay = ADDR_W'(HISTORY_DEPTH - 1);
        end else begin
            n_delay = dsum[ADDR_W-1:0];
        end
    end

    // Read address wraps around the store
    assign rd_addr = (r_wp >= r_delay) ? r_wp - r_delay
                                       : r_wp + ADDR_W'(HISTORY_DEPTH) - r_delay;

    // Both channels share one store: left in the upper half
    scdm_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write),
        .i_wr_addr (r_wp),
        .i_wr_data ({r_left_in, r_right_in}),
        .i_rd_en   (i_cmd.read),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Never-written entries read as zero
    always_comb begin
        dl_left   = r_hit ? $signed(ram_rd_data[2*SAMPLE_W-1:SAMPLE_W]) : '0;
        dl_right  = r_hit ? $signed(ram_rd_data[SAMPLE_W-1:0]) : '0;
        sum_left  = (SAMPLE_W+1)'(r_left_in) + (SAMPLE_W+1)'(dl_left);
        sum_right = (SAMPLE_W+1)'(r_right_in) + (SAMPLE_W+1)'(dl_right);
        wet_c     = (i_cfg.wet_gain > GAIN_UNITY) ? GAIN_UNITY : i_cfg.wet_gain;
        dry_c     = (i_cfg.dry_gain > GAIN_UNITY) ? GAIN_UNITY : i_cfg.dry_gain;
    end

    // Select shared multiplier operands
    always_comb begin
        case (i_cmd.mul_op)
            MUL_SWING: begin
                mul_a = $signed(MUL_A_W'(i_cfg.mod_depth));
                mul_b = $signed(MUL_B_W'(r_mag));
            end
            MUL_LW: begin
                mul_a = MUL_A_W'(sum_left);
                mul_b = $signed(MUL_B_W'(wet_c));
            end
            MUL_LD: begin
                mul_a = MUL_A_W'($signed({r_left_in, 1'b0}));
                mul_b = $signed(MUL_B_W'(dry_c));
            end
            MUL_RW: begin
                mul_a = MUL_A_W'(sum_right);
                mul_b = $signed(MUL_B_W'(wet_c));
            end
            MUL_RD: begin
                mul_a = MUL_A_W'($signed({r_right_in, 1'b0}));
                mul_b = $signed(MUL_B_W'(dry_c));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign total_r = r_acc_r + ACC_W'(r_prod);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
            end
            if (i_cmd.write) begin
                r_phase <= r_phase + i_cfg.lfo_step;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left_in  <= i_left_in;
            r_right_in <= i_right_in;
            r_mag      <= sine_mag;
            r_neg      <= sine_idx[SINE_IDX_W-1];
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.delay) begin
            r_delay <= n_delay;
        end
        if (i_cmd.read) begin
            r_hit <= FILL_W'(r_delay) < r_fill;
        end
        if (i_cmd.acc_l_load) begin
            r_acc_l <= ACC_W'(r_prod);
        end else if (i_cmd.acc_l_add) begin
            r_acc_l <= r_acc_l + ACC_W'(r_prod);
        end
        if (i_cmd.acc_r_load) begin
            r_acc_r <= ACC_W'(r_prod);
        end
        if (i_cmd.finish) begin
            r_left_out  <= round_sat(r_acc_l);
            r_right_out <= round_sat(total_r);
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_left_out        = r_left_out;
    assign o_right_out       = r_right_out;

    `SCDM_ASSERT_NEXT(a_out_hold, r_out_valid && !i_out_ready, r_out_valid && $stable(r_left_out) && $stable(r_right_out), "waiting result changed")
    `SCDM_ASSERT(a_fill_max, r_fill <= FILL_W'(HISTORY_DEPTH), "fill count beyond store depth")
    `SCDM_ASSERT(a_delay_max, !i_cmd.delay || n_delay <= ADDR_W'(HISTORY_DEPTH - 1), "delay beyond store depth")

endmodule

`default_nettype wire
